// ===== rtl/core/iida_pkg.sv =====
package iida_pkg;

  // Field widths of the transfer payloads
  localparam int unsigned ACT_W  = 3;
  localparam int unsigned POS_W  = 5;
  localparam int unsigned VAL_W  = 32;
  localparam int unsigned ST_W   = 2;
  localparam int unsigned FILL_W = 5;

  // Action codes
  localparam logic [ACT_W-1:0] ACT_APPEND = 3'd0;
  localparam logic [ACT_W-1:0] ACT_REMOVE = 3'd1;
  localparam logic [ACT_W-1:0] ACT_INSERT = 3'd2;
  localparam logic [ACT_W-1:0] ACT_DELETE = 3'd3;
  localparam logic [ACT_W-1:0] ACT_READ   = 3'd4;

  // Status codes
  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd3;

  // Command broadcast from the controller to every cell
  typedef struct packed {
    logic ins;  // write word at pos, shift entries at and above pos up
    logic del;  // shift entries above pos down onto pos
    logic rd;   // drive the entry at pos onto the read bus
  } iida_cmd_t;

endpackage

// ===== rtl/core/iida_in_if.sv =====
interface iida_in_if
  import iida_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [ACT_W-1:0] action;
  logic [POS_W-1:0] position;
  logic [VAL_W-1:0] value;

  modport source (output valid, output action, output position, output value, input ready);
  modport sink   (input valid, input action, input position, input value, output ready);
endinterface

// ===== rtl/core/iida_out_if.sv =====
interface iida_out_if
  import iida_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [ST_W-1:0]   status;
  logic [VAL_W-1:0]  read_value;
  logic [FILL_W-1:0] fill_count;

  modport source (output valid, output status, output read_value, output fill_count,
                  input ready);
  modport sink   (input valid, input status, input read_value, input fill_count,
                  output ready);
endinterface

// ===== rtl/core/iida_cell.sv =====
module iida_cell
  import iida_pkg::*;
#(
  parameter int unsigned DATA_WIDTH = 32,
  parameter int unsigned IDX_W      = 4,
  parameter int unsigned INDEX      = 0
) (
  input  logic                  clk,
  input  iida_cmd_t             cmd,
  input  logic [IDX_W-1:0]      pos_idx,
  input  logic [DATA_WIDTH-1:0] word,
  input  logic [DATA_WIDTH-1:0] left_data,
  input  logic [DATA_WIDTH-1:0] right_data,
  output logic [DATA_WIDTH-1:0] data_o,
  output logic [DATA_WIDTH-1:0] rd_o
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

  logic [DATA_WIDTH-1:0] data_r;
  logic [DATA_WIDTH-1:0] data_nxt;
  logic                  hit;
  logic                  above;

  assign hit   = (pos_idx == MY_IDX);
  assign above = (MY_IDX > pos_idx);

  // Load, take from the lower neighbor, take from the upper neighbor, or hold
  always_comb begin
    priority if (cmd.ins && hit) begin
      data_nxt = word;
    end else if (cmd.ins && above) begin
      data_nxt = left_data;
    end else if (cmd.del && (hit || above)) begin
      data_nxt = right_data;
    end else begin
      data_nxt = data_r;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_o = data_r;
  // Drive the read bus only when addressed
  assign rd_o   = (cmd.rd && hit) ? data_r : '0;

endmodule

// ===== rtl/core/indexed_insert_delete_array.sv =====
// Ordered word array with indexed insert, delete and read, built as a row of cells.
// The result is registered and valid in the cycle after its input transfer.
// Throughput: one item per cycle if results drain; all cells shift or hold together
// in that cycle and the result register frees again in the same cycle it is taken.
// Reset: synchronous active-low rst_n clears the entry count and the result valid;
// entry contents are not cleared and only positions below the count are ever read.
module indexed_insert_delete_array
  import iida_pkg::*;
#(
  parameter int unsigned DEPTH      = 16,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  iida_in_if.sink    in_ch,
  iida_out_if.source out_ch
);

  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  logic                  accept;
  logic [CNT_W-1:0]      count_r;
  logic [CNT_W-1:0]      count_nxt;
  logic [CMP_W-1:0]      pos_ext;
  logic [CMP_W-1:0]      cnt_ext;
  logic [IDX_W-1:0]      pos_idx;
  logic [IDX_W-1:0]      cell_pos;
  logic [DATA_WIDTH-1:0] word;
  logic [ST_W-1:0]       status;
  iida_cmd_t             cmd_req;
  iida_cmd_t             cmd;
  logic [DATA_WIDTH-1:0] rd_word;

  logic [DATA_WIDTH-1:0] cell_data [DEPTH];
  logic [DATA_WIDTH-1:0] cell_rd   [DEPTH];

  logic                  out_valid_r;
  logic [ST_W-1:0]       out_status_r;
  logic [VAL_W-1:0]      out_rd_r;
  logic [FILL_W-1:0]     out_fill_r;

  // Take a new item whenever the result register is empty or being drained
  assign accept      = in_ch.valid && in_ch.ready;
  assign in_ch.ready = !out_valid_r || out_ch.ready;

  assign pos_ext = CMP_W'(in_ch.position);
  assign cnt_ext = CMP_W'(count_r);
  assign pos_idx = IDX_W'(pos_ext);
  assign word    = DATA_WIDTH'(in_ch.value);

  // Decode the action: check full, empty and range, pick the cell command
  always_comb begin
    status    = ST_OK;
    cmd_req   = '0;
    count_nxt = count_r;
    cell_pos  = pos_idx;
    unique case (in_ch.action)
      ACT_APPEND: begin
        if (count_r == CNT_FULL) begin
          status = ST_FULL;
        end else begin
          cmd_req.ins = 1'b1;
          cell_pos    = IDX_W'(count_r);
          count_nxt   = count_r + 1'b1;
        end
      end
      ACT_REMOVE: begin
        if (count_r == '0) begin
          status = ST_EMPTY;
        end else begin
          count_nxt = count_r - 1'b1;
        end
      end
      ACT_INSERT: begin
        if (count_r == CNT_FULL) begin
          status = ST_FULL;
        end else if (pos_ext > cnt_ext) begin
          status = ST_RANGE;
        end else begin
          cmd_req.ins = 1'b1;
          count_nxt   = count_r + 1'b1;
        end
      end
      ACT_DELETE: begin
        if (count_r == '0) begin
          status = ST_EMPTY;
        end else if (pos_ext >= cnt_ext) begin
          status = ST_RANGE;
        end else begin
          cmd_req.del = 1'b1;
          count_nxt   = count_r - 1'b1;
        end
      end
      ACT_READ: begin
        if (count_r == '0) begin
          status = ST_EMPTY;
        end else if (pos_ext >= cnt_ext) begin
          status = ST_RANGE;
        end else begin
          cmd_req.rd = 1'b1;
        end
      end
      default: begin
        status = ST_OK;
      end
    endcase
  end

  // Gate the broadcast so cells only move on a transfer
  assign cmd = accept ? cmd_req : '0;

  // Row of storage cells, each linked to both neighbors
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_d;
    logic [DATA_WIDTH-1:0] right_d;

    if (g == 0) begin : g_lo
      assign left_d = '0;
    end else begin : g_lo_link
      assign left_d = cell_data[g-1];
    end

    if (g == DEPTH - 1) begin : g_hi
      assign right_d = '0;
    end else begin : g_hi_link
      assign right_d = cell_data[g+1];
    end

    iida_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .IDX_W      (IDX_W),
      .INDEX      (g)
    ) u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .pos_idx    (cell_pos),
      .word       (word),
      .left_data  (left_d),
      .right_data (right_d),
      .data_o     (cell_data[g]),
      .rd_o       (cell_rd[g])
    );
  end

  // Merge the read bus; at most one cell drives it
  always_comb begin
    rd_word = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rd_word = rd_word | cell_rd[i];
    end
  end

  // Hold the count and the result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Capture the result payload on each transfer
  always_ff @(posedge clk) begin
    if (accept) begin
      out_status_r <= status;
      out_rd_r     <= VAL_W'(rd_word);
      out_fill_r   <= FILL_W'(count_nxt);
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.status     = out_status_r;
  assign out_ch.read_value = out_rd_r;
  assign out_ch.fill_count = out_fill_r;

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import iida_pkg::*;

  localparam int unsigned ARR_DEPTH   = 16;
  localparam int unsigned HOLD_CYCLES = 50;
  localparam int unsigned RANDOM_ITEMS = 1400;
  localparam int unsigned DRAIN_LIMIT = 2000;
  localparam int unsigned MAX_REPORTS = 10;
  localparam int unsigned EXP_DEPTH   = 4096;

  // Action codes the block ignores
  localparam logic [ACT_W-1:0] ACT_SPARE_LO  = 3'd5;
  localparam logic [ACT_W-1:0] ACT_SPARE_MID = 3'd6;
  localparam logic [ACT_W-1:0] ACT_SPARE_HI  = 3'd7;

  typedef struct packed {
    logic [ST_W-1:0]   status;
    logic [VAL_W-1:0]  read_value;
    logic [FILL_W-1:0] fill_count;
  } array_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  iida_in_if  in_ch ();
  iida_out_if out_ch ();

  indexed_insert_delete_array #(
    .DEPTH      (ARR_DEPTH),
    .DATA_WIDTH (VAL_W)
  ) DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Shadow copy of the array contents and fill count
  logic [VAL_W-1:0]  shadow_words [ARR_DEPTH];
  logic [FILL_W-1:0] shadow_count = '0;

  // Ring of expected results, written at input transfers, read at result transfers
  array_result_t expected_results [EXP_DEPTH];
  int unsigned   exp_wr_cnt = 0;
  int unsigned   exp_rd_cnt = 0;

  bit          in_taken = 1'b0;
  bit          sender_idle_on = 1'b0;
  bit          sink_idle_on = 1'b0;
  bit          hold_request = 1'b0;
  int unsigned sink_wait = 0;
  int unsigned items_sent = 0;
  int unsigned results_checked = 0;
  int unsigned error_count = 0;
  int unsigned status_hits [4] = '{0, 0, 0, 0};

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Gap length: mostly short, now and then long
  function automatic int unsigned pick_gap();
    if ($urandom_range(0, 9) == 0) return $urandom_range(8, 30);
    return $urandom_range(1, 3);
  endfunction

  // Number of expected results still waiting for their transfer
  function automatic int unsigned pending_results();
    return exp_wr_cnt - exp_rd_cnt;
  endfunction

  // Apply one action to the shadow array and return the result it should give
  function automatic array_result_t apply_to_shadow(logic [ACT_W-1:0] act,
                                                    logic [POS_W-1:0] pos,
                                                    logic [VAL_W-1:0] val);
    array_result_t r;
    int i;
    r.status     = ST_OK;
    r.read_value = '0;
    case (act)
      ACT_APPEND: begin
        if (shadow_count >= ARR_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          shadow_words[shadow_count] = val;
          shadow_count++;
        end
      end
      ACT_REMOVE: begin
        if (shadow_count == 0) r.status = ST_EMPTY;
        else shadow_count--;
      end
      ACT_INSERT: begin
        if (shadow_count >= ARR_DEPTH) begin
          r.status = ST_FULL;
        end else if (pos > shadow_count) begin
          r.status = ST_RANGE;
        end else begin
          for (i = int'(shadow_count); i > int'(pos); i--)
            shadow_words[i] = shadow_words[i-1];
          shadow_words[pos] = val;
          shadow_count++;
        end
      end
      ACT_DELETE: begin
        if (shadow_count == 0) begin
          r.status = ST_EMPTY;
        end else if (pos >= shadow_count) begin
          r.status = ST_RANGE;
        end else begin
          for (i = int'(pos); i + 1 < int'(shadow_count); i++)
            shadow_words[i] = shadow_words[i+1];
          shadow_count--;
        end
      end
      ACT_READ: begin
        if (shadow_count == 0) r.status = ST_EMPTY;
        else if (pos >= shadow_count) r.status = ST_RANGE;
        else r.read_value = shadow_words[pos];
      end
      default: begin
      end
    endcase
    r.fill_count = shadow_count;
    return r;
  endfunction

  // Record each input transfer and queue its expected result
  always @(posedge clk) begin
    array_result_t want;
    in_taken = rst_n && in_ch.valid && in_ch.ready;
    if (in_taken) begin
      want = apply_to_shadow(in_ch.action, in_ch.position, in_ch.value);
      status_hits[want.status]++;
      expected_results[exp_wr_cnt % EXP_DEPTH] = want;
      exp_wr_cnt++;
    end
  end

  task automatic report_mismatch(string field, logic [VAL_W-1:0] want, logic [VAL_W-1:0] got);
    error_count++;
    if (error_count <= MAX_REPORTS)
      $display("mismatch on result %0d, %s: expected %0h, got %0h",
               results_checked, field, want, got);
  endtask

  // Compare each result transfer with the oldest expectation
  always @(posedge clk) begin
    array_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results() == 0) begin
        error_count++;
        if (error_count <= MAX_REPORTS)
          $display("result with nothing expected: status %0h, read %0h, fill %0d",
                   out_ch.status, out_ch.read_value, out_ch.fill_count);
      end else begin
        want = expected_results[exp_rd_cnt % EXP_DEPTH];
        exp_rd_cnt++;
        if (out_ch.status !== want.status)
          report_mismatch("status", want.status, out_ch.status);
        if (out_ch.read_value !== want.read_value)
          report_mismatch("read_value", want.read_value, out_ch.read_value);
        if (out_ch.fill_count !== want.fill_count)
          report_mismatch("fill_count", want.fill_count, out_ch.fill_count);
      end
      results_checked++;
    end
  end

  // Drive result ready: long hold on request, random stalls when enabled
  always @(negedge clk) begin
    if (hold_request) begin
      sink_wait = HOLD_CYCLES;
      hold_request = 1'b0;
    end
    if (sink_wait > 0) begin
      out_ch.ready = 1'b0;
      sink_wait--;
    end else if (sink_idle_on && $urandom_range(0, 99) < 25) begin
      out_ch.ready = 1'b0;
      sink_wait = pick_gap() - 1;
    end else begin
      out_ch.ready = 1'b1;
    end
  end

  // Offer one item and hold it until the transfer happens
  task automatic send_item(logic [ACT_W-1:0] act, logic [POS_W-1:0] pos,
                           logic [VAL_W-1:0] val);
    in_ch.valid    = 1'b1;
    in_ch.action   = act;
    in_ch.position = pos;
    in_ch.value    = val;
    do @(negedge clk); while (!in_taken);
    items_sent++;
  endtask

  // Drop valid for a random gap
  task automatic sender_pause();
    int unsigned gap;
    if (sender_idle_on && $urandom_range(0, 99) < 30) begin
      gap = pick_gap();
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic test_directed();
    send_item(ACT_READ, 5'd0, 32'h0);
    send_item(ACT_REMOVE, 5'd0, 32'h0);
    send_item(ACT_DELETE, 5'd0, 32'h0);
    // insert past the count on an empty array
    send_item(ACT_INSERT, 5'd1, 32'h1234_5678);
    send_item(ACT_INSERT, 5'd0, 32'hFFFF_FFFF);
    // delete the only entry
    send_item(ACT_DELETE, 5'd0, 32'h0);
    send_item(ACT_APPEND, 5'd0, 32'h0000_0000);
    send_item(ACT_APPEND, 5'd31, 32'hFFFF_FFFF);
    // insert at the count acts as append
    send_item(ACT_INSERT, 5'd2, 32'hA5A5_A5A5);
    send_item(ACT_INSERT, 5'd0, 32'h5A5A_5A5A);
    send_item(ACT_READ, 5'd3, 32'h0);
    send_item(ACT_READ, 5'd4, 32'h0);
    send_item(ACT_READ, 5'd16, 32'h0);
    send_item(ACT_DELETE, 5'd1, 32'h0);
    send_item(ACT_SPARE_LO, 5'd0, 32'hDEAD_BEEF);
    send_item(ACT_SPARE_MID, 5'd16, 32'h0);
    send_item(ACT_SPARE_HI, 5'd1, 32'hFFFF_FFFF);
    in_ch.valid = 1'b0;
  endtask

  // Hold the result side off while items keep coming; fill to full on the way
  task automatic test_backpressure();
    hold_request = 1'b1;
    while (shadow_count < ARR_DEPTH)
      send_item(ACT_INSERT, POS_W'($urandom_range(0, shadow_count)), $urandom);
    send_item(ACT_APPEND, 5'd0, $urandom);
    // an insert at the count while full is reported as full
    send_item(ACT_INSERT, 5'd16, $urandom);
    send_item(ACT_READ, 5'd15, 32'h0);
    send_item(ACT_DELETE, 5'd15, 32'h0);
    send_item(ACT_DELETE, 5'd0, 32'h0);
    send_item(ACT_INSERT, 5'd16, $urandom);
    send_item(ACT_READ, 5'd0, 32'h0);
    in_ch.valid = 1'b0;
  endtask

  // Build one random item, mostly well formed, leaning toward grow or shrink
  task automatic send_random_item(bit grow);
    logic [ACT_W-1:0] act;
    logic [POS_W-1:0] pos;
    logic [VAL_W-1:0] val;
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 2) act = ACT_W'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI));
    else if (roll < 27) act = ACT_READ;
    else if ((grow && roll < 75) || (!grow && roll >= 75))
      act = $urandom_range(0, 1) ? ACT_APPEND : ACT_INSERT;
    else
      act = $urandom_range(0, 1) ? ACT_REMOVE : ACT_DELETE;

    if ($urandom_range(0, 99) < 15) pos = POS_W'($urandom_range(0, ARR_DEPTH));
    else if (act == ACT_INSERT) pos = POS_W'($urandom_range(0, shadow_count));
    else if (shadow_count == 0) pos = '0;
    else pos = POS_W'($urandom_range(0, shadow_count - 1));

    roll = $urandom_range(0, 99);
    if (roll < 5) val = '0;
    else if (roll < 10) val = '1;
    else val = $urandom;

    send_item(act, pos, val);
  endtask

  // Random traffic in three phases: idling on, idling off, idling on
  task automatic test_random_traffic();
    bit grow;
    int unsigned run_left;
    grow = 1'b1;
    run_left = $urandom_range(30, 60);
    for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 3) begin
        sender_idle_on = 1'b0;
        sink_idle_on   = 1'b0;
      end else if (n == 2 * RANDOM_ITEMS / 3 || n == 0) begin
        sender_idle_on = 1'b1;
        sink_idle_on   = 1'b1;
      end
      if (run_left == 0) begin
        grow = !grow;
        run_left = $urandom_range(30, 60);
      end
      run_left--;
      send_random_item(grow);
      sender_pause();
    end
    in_ch.valid = 1'b0;
  endtask

  initial begin
    int unsigned waited;
    in_ch.valid    = 1'b0;
    in_ch.action   = '0;
    in_ch.position = '0;
    in_ch.value    = '0;
    out_ch.ready   = 1'b0;
    rst_n          = 1'b0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_backpressure();
    test_random_traffic();

    // Wait for outstanding results, then check that none are left
    waited = 0;
    while (pending_results() != 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    repeat (4) @(negedge clk);
    if (pending_results() != 0) begin
      $display("%0d expected results never arrived", pending_results());
      error_count += pending_results();
    end

    $display("sent %0d items, checked %0d results, %0d errors",
             items_sent, results_checked, error_count);
    $display("status mix: ok %0d, full %0d, empty %0d, bad position %0d",
             status_hits[ST_OK], status_hits[ST_FULL], status_hits[ST_EMPTY],
             status_hits[ST_RANGE]);
    if (error_count == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

  // Guard against a hung handshake
  initial begin
    #(12 * 300000);
    $display("timeout waiting on the array");
    $display("tb_top failed");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/iida_pkg.sv
rtl/core/iida_in_if.sv
rtl/core/iida_out_if.sv
rtl/core/iida_cell.sv
rtl/core/indexed_insert_delete_array.sv
tb/sv/tb_top.sv
